>>> sv/relative_path_normalizer_core_assert.svh
// Assertion macros shared by the checker of the relative path normalizer.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef RELATIVE_PATH_NORMALIZER_CORE_ASSERT_SVH
`define RELATIVE_PATH_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RPN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn assertion failed");

// Next-cycle implication, disabled during reset.
`define RPN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn assertion failed");

`endif

>>> sv/rpn_pkg.sv
// Types and constants of the relative path normalizer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rpn_pkg;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_INVALID_PATH = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL    = 2'd2;
    localparam logic [1:0] ST_INVALID_ARG  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_QUEST = 8'h3f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_PIPE  = 8'h7c;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam int SLOTS   = 4;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    typedef struct packed {
        logic [2:0]            count;
        logic [SLOTS-1:0][7:0] bytes;
        logic                  done;
        logic [1:0]            status;
    } plan_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> sv/rpn_front.sv
// Front part of the relative path normalizer: classifies each path byte,
// keeps the per-path state and turns each byte into a plan of output beats.
// Depends on rpn_pkg.
module rpn_front #(
    parameter int SIZE_W   = 9,
    parameter int MAX_PATH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     path_byte,
    input  logic           cfg_write,
    input  logic [8:0]     cfg_data,
    output logic           push,
    output rpn_pkg::plan_t plan
);

    logic [SIZE_W-1:0] out_size_reg;
    logic [SIZE_W-1:0] wc_reg, wc_next;
    logic [1:0]        held_reg, held_next;
    logic              open_reg, open_next;
    logic [1:0]        pos_reg, pos_next;
    logic              fwl_reg, fwl_next;
    logic              err_reg, err_next;
    logic [1:0]        kind_reg, kind_next;

    always_comb
    begin
        logic              is_sep;
        logic              is_letter;
        logic              is_upper;
        logic              is_bad;
        logic [7:0]        lc;
        logic [2:0]        sep_cnt;
        logic [2:0]        prefix;
        logic [2:0]        avail;
        logic [2:0]        n;
        logic [SIZE_W-1:0] diff;

        is_sep    = (path_byte == rpn_pkg::CH_SLASH) || (path_byte == rpn_pkg::CH_BSLASH);
        is_upper  = (path_byte >= rpn_pkg::CH_UP_A) && (path_byte <= rpn_pkg::CH_UP_Z);
        is_letter = is_upper ||
                    ((path_byte >= rpn_pkg::CH_LO_A) && (path_byte <= rpn_pkg::CH_LO_Z));
        is_bad    = (path_byte < rpn_pkg::CH_SPACE) || (path_byte >= rpn_pkg::CH_DEL) ||
                    (path_byte == rpn_pkg::CH_COLON) || (path_byte == rpn_pkg::CH_STAR) ||
                    (path_byte == rpn_pkg::CH_QUEST) || (path_byte == rpn_pkg::CH_DQUOT) ||
                    (path_byte == rpn_pkg::CH_LT) || (path_byte == rpn_pkg::CH_GT) ||
                    (path_byte == rpn_pkg::CH_PIPE) || (path_byte == rpn_pkg::CH_SPACE);
        lc        = is_upper ? (path_byte + rpn_pkg::CASE_OFFSET) : path_byte;

        sep_cnt = (!open_reg && (wc_reg != '0)) ? 3'd1 : 3'd0;
        prefix  = open_reg ? 3'd0 : (sep_cnt + {1'b0, held_reg});
        if (out_size_reg > wc_reg)
        begin
            diff  = out_size_reg - wc_reg - SIZE_W'(1);
            avail = (diff >= SIZE_W'(4)) ? 3'd4 : diff[2:0];
        end
        else
        begin
            diff  = '0;
            avail = 3'd0;
        end

        wc_next   = wc_reg;
        held_next = held_reg;
        open_next = open_reg;
        pos_next  = pos_reg;
        fwl_next  = fwl_reg;
        err_next  = err_reg;
        kind_next = kind_reg;
        n         = 3'd0;
        push      = 1'b0;
        plan      = '0;

        if (path_byte == rpn_pkg::CH_NUL)
        begin
            plan.count = 3'd1;
            plan.done  = 1'b1;
            if (err_reg)
            begin
                plan.status = kind_reg;
            end
            else if ((pos_reg == 2'd0) || (held_reg == 2'd2) || (wc_reg == '0))
            begin
                plan.status = rpn_pkg::ST_INVALID_PATH;
            end
            else
            begin
                plan.status = rpn_pkg::ST_OK;
            end
            push      = 1'b1;
            wc_next   = '0;
            held_next = 2'd0;
            open_next = 1'b0;
            pos_next  = 2'd0;
            fwl_next  = 1'b0;
            err_next  = 1'b0;
            kind_next = rpn_pkg::ST_OK;
        end
        else
        begin
            if (pos_reg == 2'd0)
            begin
                if ((out_size_reg == '0) && !err_next)
                begin
                    err_next  = 1'b1;
                    kind_next = rpn_pkg::ST_INVALID_ARG;
                end
                if (is_sep && !err_next)
                begin
                    err_next  = 1'b1;
                    kind_next = rpn_pkg::ST_INVALID_PATH;
                end
                fwl_next = is_letter;
            end
            else if (pos_reg == 2'd1)
            begin
                if (fwl_reg && (path_byte == rpn_pkg::CH_COLON) &&
                    (!err_next || (kind_next == rpn_pkg::ST_TOO_SMALL)))
                begin
                    err_next  = 1'b1;
                    kind_next = rpn_pkg::ST_INVALID_PATH;
                end
            end
            if (pos_reg < 2'd2)
            begin
                pos_next = pos_reg + 2'd1;
            end

            if (!err_next)
            begin
                if (is_sep)
                begin
                    if (held_reg == 2'd2)
                    begin
                        err_next  = 1'b1;
                        kind_next = rpn_pkg::ST_INVALID_PATH;
                    end
                    held_next = 2'd0;
                    open_next = 1'b0;
                end
                else if ((path_byte == rpn_pkg::CH_DOT) && !open_reg && (held_reg < 2'd2))
                begin
                    held_next = held_reg + 2'd1;
                end
                else
                begin
                    held_next = 2'd0;
                    open_next = 1'b1;
                    if (prefix > avail)
                    begin
                        n         = avail;
                        err_next  = 1'b1;
                        kind_next = rpn_pkg::ST_TOO_SMALL;
                    end
                    else if (is_bad)
                    begin
                        n         = prefix;
                        err_next  = 1'b1;
                        kind_next = rpn_pkg::ST_INVALID_PATH;
                    end
                    else if (prefix + 3'd1 > avail)
                    begin
                        n         = prefix;
                        err_next  = 1'b1;
                        kind_next = rpn_pkg::ST_TOO_SMALL;
                    end
                    else
                    begin
                        n = prefix + 3'd1;
                    end
                end
            end

            wc_next    = wc_reg + SIZE_W'(n);
            push       = (n != 3'd0);
            plan.count = n;
            for (int j = 0; j < rpn_pkg::SLOTS; j++)
            begin
                if (3'(j) < sep_cnt)
                begin
                    plan.bytes[j] = rpn_pkg::CH_SLASH;
                end
                else if (3'(j) < prefix)
                begin
                    plan.bytes[j] = rpn_pkg::CH_DOT;
                end
                else
                begin
                    plan.bytes[j] = lc;
                end
            end
        end

        if (!take)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg <= SIZE_W'(MAX_PATH);
            wc_reg       <= '0;
            held_reg     <= 2'd0;
            open_reg     <= 1'b0;
            pos_reg      <= 2'd0;
            fwl_reg      <= 1'b0;
            err_reg      <= 1'b0;
            kind_reg     <= rpn_pkg::ST_OK;
        end
        else
        begin
            if (cfg_write)
            begin
                out_size_reg <= SIZE_W'(cfg_data);
            end
            if (take)
            begin
                wc_reg   <= wc_next;
                held_reg <= held_next;
                open_reg <= open_next;
                pos_reg  <= pos_next;
                fwl_reg  <= fwl_next;
                err_reg  <= err_next;
                kind_reg <= kind_next;
            end
        end
    end

endmodule

>>> sv/rpn_queue.sv
// Short plan queue between the front and back parts of the path normalizer.
// Depends on rpn_pkg.
module rpn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rpn_pkg::plan_t    push_plan,
    input  logic              pop,
    output rpn_pkg::plan_t    head,
    output rpn_pkg::q_status_t qs
);

    rpn_pkg::plan_t                  mem [rpn_pkg::QDEPTH];
    logic [rpn_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [rpn_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [rpn_pkg::QPTR_W:0]        count_reg;

    assign head     = mem[rd_ptr_reg];
    assign qs.full  = (count_reg == (rpn_pkg::QPTR_W+1)'(rpn_pkg::QDEPTH));
    assign qs.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/rpn_back.sv
// Back part of the path normalizer: steps through the beats of the head plan
// and presents them in an output register. Depends on rpn_pkg.
module rpn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::plan_t     head,
    input  rpn_pkg::q_status_t qs,
    output logic               pop,
    input  logic               result_stall,
    output logic               result_valid,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               path_done,
    output logic [1:0]         status,
    output logic               last_of_run
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] byte_reg;
    logic       bv_reg;
    logic       done_reg;
    logic [1:0] status_reg;
    logic       last_reg;
    logic       load;
    logic       last_beat;

    assign load      = !valid_reg || !result_stall;
    assign last_beat = (({1'b0, idx_reg} + 3'd1) == head.count);
    assign pop       = load && !qs.empty && last_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= !qs.empty;
            if (!qs.empty)
            begin
                idx_reg <= last_beat ? 2'd0 : (idx_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !qs.empty)
        begin
            byte_reg   <= head.done ? rpn_pkg::CH_NUL : head.bytes[idx_reg];
            bv_reg     <= !head.done;
            done_reg   <= head.done;
            status_reg <= head.done ? head.status : rpn_pkg::ST_OK;
            last_reg   <= last_beat;
        end
    end

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign byte_valid   = bv_reg;
    assign path_done    = done_reg;
    assign status       = status_reg;
    assign last_of_run  = last_reg;

endmodule

>>> sv/relative_path_normalizer_core.sv
// Relative path normalizer, top level. Uses rpn_pkg, rpn_front, rpn_queue, rpn_back.
// Path bytes arrive one per beat on path_valid/path_stall; a zero byte ends the path.
// Each byte gives zero to four result beats on result_valid/result_stall: emitted
// bytes with byte_valid set, and one beat with path_done and status for the end.
// The last beat caused by a byte carries last_of_run. A byte that emits nothing
// gives no beat. The buffer size register is written on cfg_valid/cfg_ready and
// is always ready; the user must write it only while no path byte is in flight;
// the block does not enforce this. The front takes one byte per cycle unless the
// queue is full. A byte's plan is written into the queue and, at the queue head,
// loaded into the output register. The back sends one beat per cycle while
// result_stall is low, so a byte's beats occupy the back one after another; the
// four-entry plan queue absorbs that and path_stall rises only when it is full.
// Reset clears all path state, empties the queue and the output register, and sets
// the buffer size to MAX_PATH. While result_stall is high the output beat holds.
module relative_path_normalizer_core #(
    parameter int MAX_PATH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       path_valid,
    output logic       path_stall,
    input  logic [7:0] path_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       path_done,
    output logic [1:0] status,
    output logic       last_of_run
);

    localparam int SIZE_W = ($clog2(MAX_PATH + 1) > 9) ? $clog2(MAX_PATH + 1) : 9;

    rpn_pkg::plan_t     plan;
    rpn_pkg::plan_t     head;
    rpn_pkg::q_status_t qs;
    logic               push;
    logic               pop;
    logic               take;

    assign cfg_ready  = 1'b1;
    assign path_stall = qs.full;
    assign take       = path_valid && !qs.full;

    rpn_front #(
        .SIZE_W   (SIZE_W),
        .MAX_PATH (MAX_PATH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .path_byte (path_byte),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .plan      (plan)
    );

    rpn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_plan (plan),
        .pop       (pop),
        .head      (head),
        .qs        (qs)
    );

    rpn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qs           (qs),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .path_done    (path_done),
        .status       (status),
        .last_of_run  (last_of_run)
    );

endmodule

>>> sv/rpn_checker.sv
// Port-level checker for the relative path normalizer and its bind statement.
// Depends on relative_path_normalizer_core_assert.svh and rpn_pkg.
`include "relative_path_normalizer_core_assert.svh"

module rpn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       path_done,
    input logic [1:0] status
);

    `RPN_ASSERT_IMP(a_done_no_byte, result_valid && path_done, !byte_valid && (out_byte == 8'h00))
    `RPN_ASSERT_IMP(a_byte_status_ok, result_valid && !path_done, byte_valid && status == rpn_pkg::ST_OK)
    `RPN_ASSERT_IMP(a_lowercase_only, result_valid && byte_valid, (out_byte < 8'h41) || (out_byte > 8'h5a))
    `RPN_ASSERT_NXT(a_stall_holds, result_valid && result_stall, result_valid && $stable(out_byte))

endmodule

bind relative_path_normalizer_core rpn_checker u_rpn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .path_done    (path_done),
    .status       (status)
);

>>> sim/path_normalizer_checker.sv
// Checker for the relative path normalizer: watches the path, buffer size and result
// channels, predicts every result beat and compares it. Depends on rpn_pkg.
module path_normalizer_checker #(
    parameter int MAX_PATH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       path_valid,
    input  logic       path_stall,
    input  logic [7:0] path_byte,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [8:0] cfg_data,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [7:0] out_byte,
    input  logic       byte_valid,
    input  logic       path_done,
    input  logic [1:0] status,
    input  logic       last_of_run,
    output int         mismatch_count,
    output int         pending_beats,
    output int         beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       done;
        logic [1:0] code;
        logic       last;
    } beat_t;

    logic [8:0] size_limit;
    logic [8:0] emitted_count;
    logic [1:0] dot_run;
    logic       in_segment;
    logic [1:0] path_pos;
    logic       lead_letter;
    logic       err_seen;
    logic [1:0] err_code;
    beat_t      expected_beats[$];
    beat_t      step_beats[$];
    int         fail_total;
    int         checked_total;

    function automatic logic is_separator(input logic [7:0] b);
        return b == rpn_pkg::CH_SLASH || b == rpn_pkg::CH_BSLASH;
    endfunction

    function automatic logic is_upper_letter(input logic [7:0] b);
        return b >= rpn_pkg::CH_UP_A && b <= rpn_pkg::CH_UP_Z;
    endfunction

    function automatic logic is_lower_letter(input logic [7:0] b);
        return b >= rpn_pkg::CH_LO_A && b <= rpn_pkg::CH_LO_Z;
    endfunction

    function automatic logic is_invalid_char(input logic [7:0] b);
        return b < rpn_pkg::CH_SPACE || b >= rpn_pkg::CH_DEL ||
               b == rpn_pkg::CH_COLON || b == rpn_pkg::CH_STAR ||
               b == rpn_pkg::CH_QUEST || b == rpn_pkg::CH_DQUOT ||
               b == rpn_pkg::CH_LT || b == rpn_pkg::CH_GT ||
               b == rpn_pkg::CH_PIPE || b == rpn_pkg::CH_SPACE;
    endfunction

    task automatic latch_error(input logic [1:0] code);
        if (!err_seen)
        begin
            err_seen = 1'b1;
            err_code = code;
        end
    endtask

    task automatic emit_char(input logic [7:0] c);
        if (!err_seen)
        begin
            if (int'(emitted_count) + 1 >= int'(size_limit))
            begin
                latch_error(rpn_pkg::ST_TOO_SMALL);
            end
            else
            begin
                step_beats.push_back('{c, 1'b1, 1'b0, rpn_pkg::ST_OK, 1'b0});
                emitted_count++;
            end
        end
    endtask

    task automatic clear_path_state();
        emitted_count = '0;
        dot_run       = '0;
        in_segment    = 1'b0;
        path_pos      = '0;
        lead_letter   = 1'b0;
        err_seen      = 1'b0;
        err_code      = rpn_pkg::ST_OK;
    endtask

    task automatic advance_normalizer(input logic [7:0] b);
        logic [7:0] lowered;
        logic [1:0] end_code;
        beat_t      tail;
        step_beats.delete();
        if (b == rpn_pkg::CH_NUL)
        begin
            if (path_pos == 2'd0) latch_error(rpn_pkg::ST_INVALID_PATH);
            if (dot_run == 2'd2) latch_error(rpn_pkg::ST_INVALID_PATH);
            if (emitted_count == '0) latch_error(rpn_pkg::ST_INVALID_PATH);
            end_code = err_seen ? err_code : rpn_pkg::ST_OK;
            step_beats.push_back('{rpn_pkg::CH_NUL, 1'b0, 1'b1, end_code, 1'b0});
            clear_path_state();
        end
        else
        begin
            if (path_pos == 2'd0)
            begin
                if (size_limit == '0) latch_error(rpn_pkg::ST_INVALID_ARG);
                if (is_separator(b)) latch_error(rpn_pkg::ST_INVALID_PATH);
                lead_letter = is_upper_letter(b) || is_lower_letter(b);
            end
            else if (path_pos == 2'd1)
            begin
                if (lead_letter && b == rpn_pkg::CH_COLON &&
                    (!err_seen || err_code == rpn_pkg::ST_TOO_SMALL))
                begin
                    err_seen = 1'b1;
                    err_code = rpn_pkg::ST_INVALID_PATH;
                end
            end
            if (path_pos < 2'd2) path_pos++;

            if (!err_seen)
            begin
                if (is_separator(b))
                begin
                    if (dot_run == 2'd2) latch_error(rpn_pkg::ST_INVALID_PATH);
                    dot_run    = '0;
                    in_segment = 1'b0;
                end
                else if (b == rpn_pkg::CH_DOT && !in_segment && dot_run < 2'd2)
                begin
                    dot_run++;
                end
                else
                begin
                    if (!in_segment)
                    begin
                        if (emitted_count != '0) emit_char(rpn_pkg::CH_SLASH);
                        for (int k = 0; k < int'(dot_run); k++) emit_char(rpn_pkg::CH_DOT);
                        dot_run    = '0;
                        in_segment = 1'b1;
                    end
                    if (!err_seen)
                    begin
                        if (is_invalid_char(b))
                        begin
                            latch_error(rpn_pkg::ST_INVALID_PATH);
                        end
                        else
                        begin
                            lowered = is_upper_letter(b) ? b + rpn_pkg::CASE_OFFSET : b;
                            emit_char(lowered);
                        end
                    end
                end
            end
        end
        if (step_beats.size() > 0)
        begin
            tail      = step_beats.pop_back();
            tail.last = 1'b1;
            step_beats.push_back(tail);
        end
        foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        beat_t seen;
        beat_t want;
        if (!rst_n)
        begin
            size_limit = 9'(MAX_PATH);
            clear_path_state();
            expected_beats.delete();
            fail_total    = 0;
            checked_total = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) size_limit = cfg_data;
            if (path_valid && !path_stall) advance_normalizer(path_byte);
            if (result_valid && !result_stall)
            begin
                seen = '{out_byte, byte_valid, path_done, status, last_of_run};
                checked_total++;
                if (expected_beats.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("Unexpected result beat: out_byte=%02h byte_valid=%0b",
                                 out_byte, byte_valid, " path_done=%0b status=%0d last=%0b",
                                 path_done, status, last_of_run);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (seen !== want)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("Result beat %0d mismatch: expected %02h/%0b/%0b/%0d/%0b",
                                     checked_total, want.data, want.data_valid, want.done,
                                     want.code, want.last, ", got %02h/%0b/%0b/%0d/%0b",
                                     seen.data, seen.data_valid, seen.done, seen.code,
                                     seen.last);
                    end
                end
            end
        end
        mismatch_count <= fail_total;
        pending_beats  <= expected_beats.size();
        beats_checked  <= checked_total;
    end

endmodule

>>> sim/relative_path_normalizer_core_test.sv
// Testbench top for relative_path_normalizer_core: drives path bytes, buffer sizes
// and result stalls, and gives the verdict. Depends on rpn_pkg and path_normalizer_checker.
module relative_path_normalizer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         PHASE_BYTES   = 10;
    localparam int         LONG_PATH_LEN = 100;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_DASH       = 8'h2d;
    localparam logic [7:0] CH_UNDER      = 8'h5f;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       path_valid   = 1'b0;
    logic [7:0] path_byte    = 8'h00;
    logic       cfg_valid    = 1'b0;
    logic [8:0] cfg_data     = 9'd0;
    logic       result_stall = 1'b0;
    logic       calm         = 1'b0;
    logic       path_stall;
    logic       cfg_ready;
    logic       result_valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       path_done;
    logic [1:0] status;
    logic       last_of_run;
    int         mismatch_count;
    int         pending_beats;
    int         beats_checked;
    int         bytes_sent;
    int         paths_sent;
    int         size_writes;
    logic [7:0] work_path[$];

    always #5 clk = ~clk;

    relative_path_normalizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .path_valid   (path_valid),
        .path_stall   (path_stall),
        .path_byte    (path_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .path_done    (path_done),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    path_normalizer_checker #(.MAX_PATH(256)) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .path_valid     (path_valid),
        .path_stall     (path_stall),
        .path_byte      (path_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .path_done      (path_done),
        .status         (status),
        .last_of_run    (last_of_run),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats),
        .beats_checked  (beats_checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(rpn_pkg::CH_LO_A, rpn_pkg::CH_LO_Z));
        return 8'($urandom_range(rpn_pkg::CH_UP_A, rpn_pkg::CH_UP_Z));
    endfunction

    function automatic logic [7:0] pick_separator();
        return ($urandom_range(0, 1) == 0) ? rpn_pkg::CH_SLASH : rpn_pkg::CH_BSLASH;
    endfunction

    function automatic logic [7:0] seg_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 62) return pick_letter();
        if (r < 76) return 8'($urandom_range(CH_ZERO, CH_NINE));
        if (r < 84) return ($urandom_range(0, 1) == 0) ? CH_DASH : CH_UNDER;
        if (r < 90) return rpn_pkg::CH_DOT;
        if (r < 95)
        begin
            case ($urandom_range(0, 8))
                0: return rpn_pkg::CH_COLON;
                1: return rpn_pkg::CH_STAR;
                2: return rpn_pkg::CH_QUEST;
                3: return rpn_pkg::CH_DQUOT;
                4: return rpn_pkg::CH_LT;
                5: return rpn_pkg::CH_GT;
                6: return rpn_pkg::CH_PIPE;
                7: return rpn_pkg::CH_SPACE;
                default: return rpn_pkg::CH_DEL;
            endcase
        end
        return 8'($urandom_range(1, 255));
    endfunction

    initial
    begin : stall_gen
        int run_len;
        forever
        begin
            run_len = $urandom_range(1, 8);
            repeat (run_len)
            begin
                @(posedge clk);
                result_stall <= 1'b0;
            end
            run_len = pick_gap();
            repeat (run_len)
            begin
                @(posedge clk);
                result_stall <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            path_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        path_valid <= 1'b1;
        path_byte  <= b;
        do @(posedge clk); while (path_stall);
        bytes_sent++;
    endtask

    task automatic send_path();
        foreach (work_path[i]) send_byte(work_path[i]);
        send_byte(rpn_pkg::CH_NUL);
        paths_sent++;
    endtask

    task automatic send_text(input string s);
        work_path.delete();
        for (int i = 0; i < s.len(); i++) work_path.push_back(s[i]);
        send_path();
    endtask

    task automatic drain();
        path_valid <= 1'b0;
        do @(posedge clk); while (pending_beats != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_out_size(input logic [8:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_writes++;
    endtask

    task automatic compose_path();
        int kind;
        int nseg;
        int r;
        work_path.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 6)) work_path.push_back(8'($urandom_range(1, 255)));
        end
        else if (kind >= 13)
        begin
            if (kind < 17)
            begin
                work_path.push_back(pick_separator());
            end
            else if (kind < 22)
            begin
                work_path.push_back(pick_letter());
                work_path.push_back(rpn_pkg::CH_COLON);
            end
            nseg = $urandom_range(1, 4);
            for (int seg = 0; seg < nseg; seg++)
            begin
                if (seg > 0) repeat ($urandom_range(1, 3)) work_path.push_back(pick_separator());
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    work_path.push_back(rpn_pkg::CH_DOT);
                end
                else if (r < 14)
                begin
                    work_path.push_back(rpn_pkg::CH_DOT);
                    work_path.push_back(rpn_pkg::CH_DOT);
                end
                else
                begin
                    if (r < 24) repeat ($urandom_range(1, 3)) work_path.push_back(rpn_pkg::CH_DOT);
                    repeat ($urandom_range(1, 6)) work_path.push_back(seg_char());
                end
            end
            if ($urandom_range(0, 4) == 0) work_path.push_back(pick_separator());
        end
    endtask

    initial
    begin : stimulus
        logic [8:0] size_plan[8];
        bit         timed_out;
        int         quiet;
        int         phase_start;
        size_plan    = '{9'd256, 9'd3, 9'd0, 9'd1, 9'd17, 9'd2, 9'd4, 9'd255};
        size_plan[6] = 9'($urandom_range(4, 64));
        timed_out    = 1'b0;
        bytes_sent   = 0;
        paths_sent   = 0;
        size_writes  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                send_text("");
                send_text("/");
                send_text("c:");
                send_text("..");
                send_text("./");
                send_text("...Z\\/b");
                work_path.delete();
                work_path.push_back(8'hff);
                send_path();
                drain();
                write_out_size(9'd0);
                send_text("a");
                drain();
                write_out_size(9'd1);
                send_text("C:");
                for (int p = 0; p < 8; p++)
                begin
                    drain();
                    write_out_size(size_plan[p]);
                    calm <= (p % 3 == 2);
                    if (p == 7)
                    begin
                        work_path.delete();
                        repeat (LONG_PATH_LEN)
                            work_path.push_back(($urandom_range(0, 15) == 0) ?
                                                pick_separator() : pick_letter());
                        send_path();
                    end
                    phase_start = bytes_sent;
                    while (bytes_sent - phase_start < PHASE_BYTES)
                    begin
                        compose_path();
                        send_path();
                    end
                end
                drain();
            end
            begin
                quiet = 0;
                while (quiet < QUIET_LIMIT)
                begin
                    @(posedge clk);
                    if ((path_valid && !path_stall) || (result_valid && !result_stall) ||
                        (cfg_valid && cfg_ready))
                        quiet = 0;
                    else
                        quiet++;
                end
                timed_out = 1'b1;
            end
        join_any
        $display("Sent %0d path bytes in %0d paths across %0d buffer size writes;",
                 bytes_sent, paths_sent, size_writes);
        $display("compared %0d result beats, %0d mismatched, %0d still outstanding.",
                 beats_checked, mismatch_count, pending_beats);
        if (!timed_out && mismatch_count == 0 && pending_beats == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
